// ===== rtl/wfpc_pkg.sv =====
// wfpc_pkg: types and constants shared by the wall-follow pid controller
// no dependencies; imported by the interfaces, the top level and the checker

package wfpc_pkg;

	localparam int SCAN_MAX_DEF = 1024;

	localparam int RANGE_W  = 16;
	localparam int INDEX_W  = 10;
	localparam int SECTOR_W = 9;
	localparam int LEN_CFG_W = 11;
	localparam int GAIN_W   = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int ERR_W    = 17;
	localparam int DER_W    = 18;
	localparam int CMD_W    = 32;

	localparam logic [RANGE_W-1:0] RANGE_FAR = '1;
	localparam logic [15:0] COUNT_MAX = '1;

	// command constants in q16.16
	localparam logic signed [CMD_W-1:0] Q_ONE     = 32'sd65536;
	localparam logic signed [CMD_W-1:0] Q_HALF    = 32'sd32768;
	localparam logic signed [CMD_W-1:0] Q_BACKOFF = -32'sd3277;
	localparam logic signed [CMD_W-1:0] Q_ZERO    = 32'sd0;

	localparam logic signed [CMD_W-1:0] CMD_MAX = 32'sh7fff_ffff;
	localparam logic signed [CMD_W-1:0] CMD_MIN = 32'sh8000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD  = 3'd0,
		REG_TARGET     = 3'd1,
		REG_GAIN_P     = 3'd2,
		REG_GAIN_I_DT  = 3'd3,
		REG_GAIN_D_DT  = 3'd4,
		REG_LOST_LIMIT = 3'd5,
		REG_SECTOR     = 3'd6,
		REG_SCAN_LEN   = 3'd7
	} cfg_reg_t;

	typedef enum logic {
		MODE_SAMPLE = 1'b0,
		MODE_TICK   = 1'b1
	} item_mode_t;

	// branch taken by a tick, carried down the command pipeline
	typedef struct packed {
		logic avoid;
		logic lost;
		logic pid;
	} tick_ctl_t;

endpackage

// ===== rtl/wfpc_if.sv =====
// wfpc_item_if / wfpc_result_if: valid-ready channels of the controller
// depends on wfpc_pkg for field widths

interface wfpc_item_if
	import wfpc_pkg::*;
	();
	logic                 valid;
	logic                 ready;
	logic                 mode;
	logic [RANGE_W-1:0]   range_mm;
	logic [INDEX_W-1:0]   sample_index;

	modport source (output valid, mode, range_mm, sample_index, input ready);
	modport sink (input valid, mode, range_mm, sample_index, output ready);
endinterface

interface wfpc_result_if
	import wfpc_pkg::*;
	();
	logic                     valid;
	logic                     ready;
	logic signed [CMD_W-1:0]  linear_velocity;
	logic signed [CMD_W-1:0]  angular_velocity;
	logic                     is_lost;
	logic                     avoiding;

	modport source (output valid, linear_velocity, angular_velocity, is_lost, avoiding,
		input ready);
	modport sink (input valid, linear_velocity, angular_velocity, is_lost, avoiding,
		output ready);
endinterface

// ===== rtl/wall_follow_pid_controller_unit.sv =====
// wall_follow_pid_controller_unit: one item per cycle; a range sample updates the sector
// minima in the cycle it is accepted and gives no result; a control tick gives its
// command through the registered stages prep, multiply, partial sum, and final sum and saturate
// throughput: one item per clock, stalled only when the result register and all three
// command stages hold ticks that the sink has not taken
// arst_n clears control state, config registers and controller state to their defaults

module wall_follow_pid_controller_unit
	import wfpc_pkg::*;
#(
	parameter int SCAN_MAX = SCAN_MAX_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	wfpc_item_if.sink               item,
	wfpc_result_if.source           result,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);

	localparam int MAX_W = $clog2(SCAN_MAX + 1);
	localparam int LEN_W = (MAX_W > LEN_CFG_W) ? MAX_W : LEN_CFG_W;
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(SCAN_MAX);
	localparam int PP_W  = GAIN_W + ERR_W;
	localparam int PI_W  = 2 * GAIN_W;
	localparam int PD_W  = GAIN_W + DER_W;
	localparam int PPD_W = PD_W + 1;
	localparam int ACC_W = PI_W + 2;

	// configuration registers
	logic [RANGE_W-1:0]          threshold_q, target_q, lost_limit_q;
	logic signed [GAIN_W-1:0]    gain_p_q, gain_i_q, gain_d_q;
	logic [SECTOR_W-1:0]         sector_q;
	logic [LEN_CFG_W-1:0]        scan_len_q;

	// controller state
	logic [RANGE_W-1:0]          scan_right_q, scan_front_q, scan_left_q;
	logic [RANGE_W-1:0]          right_dist_q, front_dist_q, left_dist_q;
	logic [15:0]                 clear_count_q;
	logic                        lost_q;
	logic signed [ERR_W-1:0]     prev_err_q;
	logic signed [31:0]          err_sum_q;

	// pipeline
	logic                        valid_s1, valid_s2, valid_s3, out_valid_q;
	tick_ctl_t                   ctl_s1, ctl_s2, ctl_s3;
	logic signed [ERR_W-1:0]     err_s1;
	logic signed [DER_W-1:0]     der_s1;
	logic signed [31:0]          sum_s1;
	logic signed [PP_W-1:0]      prod_p_s2;
	logic signed [PI_W-1:0]      prod_i_s2;
	logic signed [PD_W-1:0]      prod_d_s2;
	logic signed [PPD_W-1:0]     pd_s3;
	logic signed [PI_W-1:0]      pi_s3;
	logic signed [CMD_W-1:0]     lin_q, ang_q;
	logic                        is_lost_q, avoid_q;

	logic out_free, free_s3, free_s2, free_s1;
	logic accept, take_sample, take_tick;

	assign out_free = !out_valid_q || result.ready;
	assign free_s3  = !valid_s3 || out_free;
	assign free_s2  = !valid_s2 || free_s3;
	assign free_s1  = !valid_s1 || free_s2;

	assign item.ready  = free_s1;
	assign accept      = item.valid && item.ready;
	assign take_sample = accept && (item.mode == MODE_SAMPLE);
	assign take_tick   = accept && (item.mode == MODE_TICK);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= 16'd500;
			target_q     <= 16'd500;
			gain_p_q     <= '0;
			gain_i_q     <= '0;
			gain_d_q     <= '0;
			lost_limit_q <= 16'd75;
			sector_q     <= 9'd341;
			scan_len_q   <= 11'd1024;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_THRESHOLD:  threshold_q  <= cfg_data[RANGE_W-1:0];
				REG_TARGET:     target_q     <= cfg_data[RANGE_W-1:0];
				REG_GAIN_P:     gain_p_q     <= $signed(cfg_data[GAIN_W-1:0]);
				REG_GAIN_I_DT:  gain_i_q     <= $signed(cfg_data[GAIN_W-1:0]);
				REG_GAIN_D_DT:  gain_d_q     <= $signed(cfg_data[GAIN_W-1:0]);
				REG_LOST_LIMIT: lost_limit_q <= cfg_data[RANGE_W-1:0];
				REG_SECTOR:     sector_q     <= cfg_data[SECTOR_W-1:0];
				REG_SCAN_LEN:   scan_len_q   <= cfg_data[LEN_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// sample path: sector select and running minima
	logic [LEN_W-1:0]      len_ext, len_eff, idx_ext;
	logic [LEN_CFG_W-1:0]  idx11, ss11, ss2x;
	logic                  in_scan, is_last, in_right, in_front;
	logic [RANGE_W-1:0]    right_n, front_n, left_n;

	always_comb begin
		len_ext = LEN_W'(scan_len_q);
		if (scan_len_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (len_ext > LEN_MAX) begin
			len_eff = LEN_MAX;
		end else begin
			len_eff = len_ext;
		end
		idx_ext  = LEN_W'(item.sample_index);
		in_scan  = idx_ext < len_eff;
		is_last  = idx_ext == (len_eff - LEN_W'(1));
		idx11    = LEN_CFG_W'(item.sample_index);
		ss11     = LEN_CFG_W'(sector_q);
		ss2x     = {1'b0, sector_q, 1'b0};
		in_right = idx11 < ss11;
		in_front = !in_right && (idx11 < ss2x);
		right_n  = scan_right_q;
		front_n  = scan_front_q;
		left_n   = scan_left_q;
		if (in_right) begin
			if (item.range_mm < scan_right_q) right_n = item.range_mm;
		end else if (in_front) begin
			if (item.range_mm < scan_front_q) front_n = item.range_mm;
		end else begin
			if (item.range_mm < scan_left_q) left_n = item.range_mm;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_right_q <= RANGE_FAR;
			scan_front_q <= RANGE_FAR;
			scan_left_q  <= RANGE_FAR;
			right_dist_q <= RANGE_FAR;
			front_dist_q <= RANGE_FAR;
			left_dist_q  <= RANGE_FAR;
		end else if (take_sample && in_scan) begin
			if (is_last) begin
				// commit the scan and start a fresh one
				right_dist_q <= right_n;
				front_dist_q <= front_n;
				left_dist_q  <= left_n;
				scan_right_q <= RANGE_FAR;
				scan_front_q <= RANGE_FAR;
				scan_left_q  <= RANGE_FAR;
			end else begin
				scan_right_q <= right_n;
				scan_front_q <= front_n;
				scan_left_q  <= left_n;
			end
		end
	end

	// tick path: lost detection and pid state update
	logic                  all_clear, near, front_near;
	logic [15:0]           count_inc, count_n;
	logic                  lost_n;
	logic signed [ERR_W-1:0]  err;
	logic signed [DER_W-1:0]  der;
	logic signed [32:0]       sum_wide;
	logic signed [31:0]       sum_sat;
	tick_ctl_t                ctl_n;

	always_comb begin
		all_clear  = (front_dist_q > threshold_q) && (right_dist_q > threshold_q)
			&& (left_dist_q > threshold_q);
		front_near = front_dist_q < threshold_q;
		near       = front_near || (right_dist_q < threshold_q);
		count_inc  = (clear_count_q != COUNT_MAX) ? clear_count_q + 16'd1 : clear_count_q;
		count_n    = clear_count_q;
		lost_n     = lost_q;
		if (all_clear) begin
			count_n = count_inc;
			if (count_inc >= lost_limit_q) lost_n = 1'b1;
		end else if (near) begin
			count_n = '0;
			lost_n  = 1'b0;
		end
		err      = $signed({1'b0, target_q}) - $signed({1'b0, right_dist_q});
		der      = DER_W'(err) - DER_W'(prev_err_q);
		sum_wide = 33'(err_sum_q) + 33'(err);
		if (sum_wide > 33'sd2147483647) begin
			sum_sat = 32'sh7fff_ffff;
		end else if (sum_wide < -33'sd2147483648) begin
			sum_sat = 32'sh8000_0000;
		end else begin
			sum_sat = sum_wide[31:0];
		end
		ctl_n.avoid = front_near;
		ctl_n.lost  = lost_n;
		ctl_n.pid   = !front_near && !lost_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_count_q <= '0;
			lost_q        <= 1'b0;
			prev_err_q    <= '0;
			err_sum_q     <= '0;
		end else if (take_tick) begin
			clear_count_q <= count_n;
			lost_q        <= lost_n;
			if (ctl_n.pid) begin
				prev_err_q <= err;
				err_sum_q  <= sum_sat;
			end
		end
	end

	// command pipeline valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (free_s1) valid_s1 <= take_tick;
			if (free_s2) valid_s2 <= valid_s1;
			if (free_s3) valid_s3 <= valid_s2;
			if (out_free) out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (free_s1) begin
			ctl_s1 <= ctl_n;
			err_s1 <= err;
			der_s1 <= der;
			sum_s1 <= sum_sat;
		end
		if (free_s2) begin
			ctl_s2    <= ctl_s1;
			prod_p_s2 <= PP_W'(gain_p_q) * PP_W'(err_s1);
			prod_i_s2 <= PI_W'(gain_i_q) * PI_W'(sum_s1);
			prod_d_s2 <= PD_W'(gain_d_q) * PD_W'(der_s1);
		end
		if (free_s3) begin
			ctl_s3 <= ctl_s2;
			pd_s3  <= PPD_W'(prod_p_s2) + PPD_W'(prod_d_s2);
			pi_s3  <= prod_i_s2;
		end
	end

	// final sum, saturation and branch select
	logic signed [ACC_W-1:0]  acc;
	logic signed [CMD_W-1:0]  ang_pid, lin_n, ang_n;

	always_comb begin
		acc = ACC_W'(pd_s3) + ACC_W'(pi_s3);
		if (acc > ACC_W'(CMD_MAX)) begin
			ang_pid = CMD_MAX;
		end else if (acc < ACC_W'(CMD_MIN)) begin
			ang_pid = CMD_MIN;
		end else begin
			ang_pid = acc[CMD_W-1:0];
		end
		priority if (ctl_s3.avoid) begin
			lin_n = Q_BACKOFF;
			ang_n = Q_ONE;
		end else if (ctl_s3.lost) begin
			lin_n = Q_HALF;
			ang_n = Q_ZERO;
		end else begin
			lin_n = Q_HALF;
			ang_n = ang_pid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			lin_q     <= lin_n;
			ang_q     <= ang_n;
			is_lost_q <= ctl_s3.lost;
			avoid_q   <= ctl_s3.avoid;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.linear_velocity  = lin_q;
	assign result.angular_velocity = ang_q;
	assign result.is_lost          = is_lost_q;
	assign result.avoiding         = avoid_q;

endmodule

// ===== rtl/wfpc_checker.sv =====
// wfpc_port_checks: port-level checks on the result channel of the controller
// depends on wfpc_pkg; bound to wall_follow_pid_controller_unit at the end of this file

module wfpc_port_checks
	import wfpc_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    result_valid,
	input logic                    result_ready,
	input logic signed [CMD_W-1:0] linear_velocity,
	input logic signed [CMD_W-1:0] angular_velocity,
	input logic                    is_lost,
	input logic                    avoiding
);

	// a stalled transaction keeps its payload
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(linear_velocity)
			&& $stable(angular_velocity) && $stable(is_lost) && $stable(avoiding))
		else $error("result payload changed while stalled");

	// nothing comes out right after reset
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !result_valid)
		else $error("result valid right after reset");

	// a close front clears lost and backs off
	a_avoid_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && avoiding |-> !is_lost && linear_velocity == Q_BACKOFF
			&& angular_velocity == Q_ONE)
		else $error("avoidance command wrong");

	// lost without avoidance drives straight
	a_lost_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && is_lost |-> !avoiding && linear_velocity == Q_HALF
			&& angular_velocity == Q_ZERO)
		else $error("lost command wrong");

endmodule

bind wall_follow_pid_controller_unit wfpc_port_checks u_wfpc_port_checks (
	.clk              (clk),
	.arst_n           (arst_n),
	.result_valid     (result.valid),
	.result_ready     (result.ready),
	.linear_velocity  (result.linear_velocity),
	.angular_velocity (result.angular_velocity),
	.is_lost          (result.is_lost),
	.avoiding         (result.avoiding)
);

// ===== dv/wfpc_checker.sv =====
// wfpc_checker: watches the item, result and register write ports of the controller,
// predicts each tick command and compares it field by field with what comes out
// depends on wfpc_pkg and the channel interfaces in wfpc_if.sv
`timescale 1ns / 1ps

module wfpc_checker
	import wfpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	wfpc_item_if                  item,
	wfpc_result_if                result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    outstanding
);

	typedef struct packed {
		logic signed [CMD_W-1:0] lin;
		logic signed [CMD_W-1:0] ang;
		logic                    lost;
		logic                    avoid;
	} command_t;

	command_t cmd_queue[$];
	int fail_total;

	// register mirror
	logic [15:0]             thr_mm, tgt_mm, lost_lim;
	logic signed [GAIN_W-1:0] kp, ki_dt, kd_dt;
	logic [SECTOR_W-1:0]     sector_len;
	logic [LEN_CFG_W-1:0]    scan_len;

	// controller state
	logic [RANGE_W-1:0]      run_right, run_front, run_left;
	logic [RANGE_W-1:0]      right_mm, front_mm, left_mm;
	logic [15:0]             clear_ticks;
	logic                    lost_now;
	logic signed [ERR_W-1:0] last_err;
	logic signed [31:0]      err_total;

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > longint'(32'sh7fff_ffff))
			return 32'sh7fff_ffff;
		if (v < -longint'(64'h8000_0000))
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	// advances the mirrored controller by one item and queues the command of a tick
	function automatic void absorb_item(input item_mode_t m, input logic [RANGE_W-1:0] r,
		input logic [INDEX_W-1:0] ix);
		int span, idx, sec, tgt, rd;
		longint e, d, s, acc;
		command_t c;
		if (m == MODE_SAMPLE) begin
			span = int'(scan_len);
			if (span < 1)
				span = 1;
			else if (span > SCAN_MAX_DEF)
				span = SCAN_MAX_DEF;
			idx = int'(ix);
			sec = int'(sector_len);
			if (idx < span) begin
				if (idx < sec) begin
					if (r < run_right) run_right = r;
				end else if (idx < 2 * sec) begin
					if (r < run_front) run_front = r;
				end else begin
					if (r < run_left) run_left = r;
				end
				if (idx == span - 1) begin
					right_mm = run_right;
					front_mm = run_front;
					left_mm = run_left;
					run_right = RANGE_FAR;
					run_front = RANGE_FAR;
					run_left = RANGE_FAR;
				end
			end
		end else begin
			if (front_mm > thr_mm && right_mm > thr_mm && left_mm > thr_mm) begin
				if (clear_ticks != COUNT_MAX)
					clear_ticks = clear_ticks + 16'd1;
				if (clear_ticks >= lost_lim)
					lost_now = 1'b1;
			end else if (front_mm < thr_mm || right_mm < thr_mm) begin
				lost_now = 1'b0;
				clear_ticks = '0;
			end
			c.avoid = 1'b0;
			if (front_mm < thr_mm) begin
				c.lin = Q_BACKOFF;
				c.ang = Q_ONE;
				c.avoid = 1'b1;
			end else if (lost_now) begin
				c.lin = Q_HALF;
				c.ang = Q_ZERO;
			end else begin
				tgt = int'(tgt_mm);
				rd = int'(right_mm);
				e = tgt - rd;
				d = e - last_err;
				s = clamp32(err_total + e);
				acc = kp * e + ki_dt * s + kd_dt * d;
				last_err = e[ERR_W-1:0];
				err_total = s[31:0];
				c.lin = Q_HALF;
				c.ang = clamp32(acc);
			end
			c.lost = lost_now;
			cmd_queue.push_back(c);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		command_t want;
		if (!arst_n) begin
			thr_mm = 16'd500;
			tgt_mm = 16'd500;
			kp = '0;
			ki_dt = '0;
			kd_dt = '0;
			lost_lim = 16'd75;
			sector_len = 9'd341;
			scan_len = 11'd1024;
			run_right = RANGE_FAR;
			run_front = RANGE_FAR;
			run_left = RANGE_FAR;
			right_mm = RANGE_FAR;
			front_mm = RANGE_FAR;
			left_mm = RANGE_FAR;
			clear_ticks = '0;
			lost_now = 1'b0;
			last_err = '0;
			err_total = '0;
			cmd_queue.delete();
			fail_total = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_THRESHOLD:  thr_mm = cfg_data[15:0];
					REG_TARGET:     tgt_mm = cfg_data[15:0];
					REG_GAIN_P:     kp = $signed(cfg_data);
					REG_GAIN_I_DT:  ki_dt = $signed(cfg_data);
					REG_GAIN_D_DT:  kd_dt = $signed(cfg_data);
					REG_LOST_LIMIT: lost_lim = cfg_data[15:0];
					REG_SECTOR:     sector_len = cfg_data[SECTOR_W-1:0];
					REG_SCAN_LEN:   scan_len = cfg_data[LEN_CFG_W-1:0];
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				if (cmd_queue.size() == 0) begin
					fail_total++;
					if (fail_total <= 10)
						$display("%0t: command with none expected: lin %0d ang %0d lost %0b avoid %0b",
							$realtime, result.linear_velocity, result.angular_velocity,
							result.is_lost, result.avoiding);
				end else begin
					want = cmd_queue.pop_front();
					if (result.linear_velocity !== want.lin || result.angular_velocity !== want.ang
						|| result.is_lost !== want.lost || result.avoiding !== want.avoid) begin
						fail_total++;
						if (fail_total <= 10)
							$display({"%0t: command mismatch: exp lin %0d ang %0d lost %0b avoid %0b,",
								" got lin %0d ang %0d lost %0b avoid %0b"}, $realtime,
								want.lin, want.ang, want.lost, want.avoid,
								result.linear_velocity, result.angular_velocity,
								result.is_lost, result.avoiding);
					end
				end
			end
			if (item.valid && item.ready)
				absorb_item(item_mode_t'(item.mode), item.range_mm, item.sample_index);
			mismatches <= fail_total;
			outstanding <= cmd_queue.size();
		end
	end

endmodule

// ===== dv/tb_top.sv =====
// tb_top: stimulus for wall_follow_pid_controller_unit: directed scans and ticks, then
// random scans over several register settings with random idling on both channels
// depends on wfpc_pkg, wfpc_if.sv, the controller rtl and wfpc_checker
`timescale 1ns / 1ps

module tb_top;
	import wfpc_pkg::*;

	localparam int QUIET_LIMIT = 500;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_ITEMS = 220;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int mismatches;
	int outstanding;
	int items_sent = 0;
	int cmds_seen = 0;
	int settings_used = 0;
	int quiet = 0;
	int hold = 0;
	int cur_thr = 500;
	int cur_len = 1024;
	bit far_bias = 1'b0;
	bit calm = 1'b0;

	wfpc_item_if item_ch ();
	wfpc_result_if result_ch ();

	wall_follow_pid_controller_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	wfpc_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// result side: random stall bursts, none in the calm stretch
	always @(posedge clk) begin
		if (calm) begin
			result_ch.ready <= 1'b1;
		end else if (hold > 0) begin
			result_ch.ready <= 1'b0;
			hold <= hold - 1;
		end else if ($urandom_range(0, 7) == 0) begin
			result_ch.ready <= 1'b0;
			hold <= $urandom_range(0, 10);
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			quiet <= 0;
			if (result_ch.valid && result_ch.ready)
				cmds_seen <= cmds_seen + 1;
		end else if (arst_n) begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end

	task automatic send_item(input item_mode_t m, input logic [RANGE_W-1:0] r,
		input logic [INDEX_W-1:0] ix);
		if (!calm && $urandom_range(0, 3) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.mode <= m;
		item_ch.range_mm <= r;
		item_ch.sample_index <= ix;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_tick();
		send_item(MODE_TICK, RANGE_W'($urandom), INDEX_W'($urandom));
	endtask

	// wait for every command, then let any sample still in flight land
	task automatic settle();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		@(posedge clk);
	endtask

	task automatic program_regs(input logic [15:0] thr, input logic [15:0] tgt,
		input logic [31:0] gp, input logic [31:0] gi, input logic [31:0] gd,
		input logic [15:0] lim, input logic [SECTOR_W-1:0] sec,
		input logic [LEN_CFG_W-1:0] len);
		settle();
		put_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
		put_reg(REG_TARGET, CFG_DATA_W'(tgt));
		put_reg(REG_GAIN_P, gp);
		put_reg(REG_GAIN_I_DT, gi);
		put_reg(REG_GAIN_D_DT, gd);
		put_reg(REG_LOST_LIMIT, CFG_DATA_W'(lim));
		put_reg(REG_SECTOR, CFG_DATA_W'(sec));
		put_reg(REG_SCAN_LEN, CFG_DATA_W'(len));
		cfg_we <= 1'b0;
		cur_thr = int'(thr);
		cur_len = (len == 0) ? 1 : (len > SCAN_MAX_DEF) ? SCAN_MAX_DEF : int'(len);
		settings_used++;
	endtask

	// ranges cluster at the extremes and around the threshold
	function automatic logic [RANGE_W-1:0] pick_range();
		int v;
		case ($urandom_range(0, 9))
			0: v = 0;
			1: v = 65535;
			2, 3: v = cur_thr + int'($urandom_range(0, 4)) - 2;
			default: begin
				if (far_bias && cur_thr < 65535)
					v = int'($urandom_range(cur_thr + 1, 65535));
				else
					v = int'($urandom_range(0, 65535));
			end
		endcase
		if (v < 0) v = 0;
		if (v > 65535) v = 65535;
		return v[RANGE_W-1:0];
	endfunction

	function automatic logic [31:0] pick_gain();
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return $urandom_range(0, 1 << 18) - (1 << 17);
	endfunction

	// one scan in index order with ticks and stray out-of-scan indices mixed in; long scans are sampled sparsely
	// but always end on the last index, and now and then a scan is abandoned
	task automatic run_scan();
		int i, step;
		i = 0;
		while (i < cur_len) begin
			if ($urandom_range(0, 5) == 0)
				repeat ($urandom_range(1, 3)) send_tick();
			if (cur_len < SCAN_MAX_DEF && $urandom_range(0, 40) == 0)
				send_item(MODE_SAMPLE, pick_range(), INDEX_W'($urandom_range(cur_len, 1023)));
			send_item(MODE_SAMPLE, pick_range(), INDEX_W'(i));
			step = (cur_len > 48) ? $urandom_range(1, cur_len / 16) : 1;
			if (i < cur_len - 1 && i + step > cur_len - 1)
				step = cur_len - 1 - i;
			i += step;
			if ($urandom_range(0, 60) == 0)
				break;
		end
	endtask

	initial begin
		logic [15:0] thr, tgt, lim;
		logic [31:0] gp, gi, gd;
		logic [SECTOR_W-1:0] sec;
		logic [LEN_CFG_W-1:0] len;
		int phase_end;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_ch.valid = 1'b0;
		item_ch.mode = 1'b0;
		item_ch.range_mm = '0;
		item_ch.sample_index = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: far minima, zero gains; last index of a full scan commits
		send_tick();
		send_item(MODE_SAMPLE, 16'd0, 10'd1023);
		send_tick();

		program_regs(16'd500, 16'd300, 32'h0001_0000, 32'h0000_0100, 32'h0000_1000,
			16'd1, 9'd1, 11'd3);
		// right wall close
		send_item(MODE_SAMPLE, 16'd0, 10'd0);
		send_item(MODE_SAMPLE, 16'd65535, 10'd1);
		send_item(MODE_SAMPLE, 16'd700, 10'd2);
		send_tick();
		// front close
		send_item(MODE_SAMPLE, 16'd600, 10'd0);
		send_item(MODE_SAMPLE, 16'd100, 10'd1);
		send_item(MODE_SAMPLE, 16'd600, 10'd2);
		send_tick();
		// all clear: lost on the first clear tick
		send_item(MODE_SAMPLE, 16'd900, 10'd0);
		send_item(MODE_SAMPLE, 16'd900, 10'd1);
		send_item(MODE_SAMPLE, 16'd900, 10'd2);
		send_tick();
		send_tick();
		// indices past the scan are dropped
		send_item(MODE_SAMPLE, 16'd0, 10'd5);
		send_item(MODE_SAMPLE, 16'd0, 10'd1023);
		send_tick();

		// zero threshold, zero sector and scan length, extreme gains and target
		program_regs(16'd0, 16'd65535, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			16'd0, 9'd0, 11'd0);
		send_item(MODE_SAMPLE, 16'd0, 10'd0);
		send_tick();
		send_item(MODE_SAMPLE, 16'd65535, 10'd0);
		send_tick();

		for (int p = 0; p < 9; p++) begin
			thr = (p == 0) ? 16'd65535 : (p == 1) ? 16'd0 : 16'($urandom_range(100, 3000));
			tgt = (p == 2) ? 16'd0 : (p == 3) ? 16'd65535 : 16'($urandom_range(0, 4000));
			gp = pick_gain();
			gi = pick_gain();
			gd = pick_gain();
			if (p == 3) begin
				gp = 32'h7fff_ffff;
				gi = 32'h7fff_ffff;
				gd = 32'h8000_0000;
			end else if (p == 4) begin
				gp = 32'h8000_0000;
				gi = 32'h8000_0000;
				gd = 32'h7fff_ffff;
			end
			lim = (p == 5) ? 16'd65535 : (p == 6) ? 16'd0 : 16'($urandom_range(1, 6));
			len = LEN_CFG_W'($urandom_range(2, 30));
			sec = SECTOR_W'($urandom_range(0, len / 3 + 2));
			if (p == 2) begin
				sec = 9'd0;
			end else if (p == 5) begin
				len = 11'd1;
			end else if (p == 6) begin
				sec = 9'd341;
				len = 11'd1024;
			end else if (p == 7) begin
				sec = 9'd341;
				len = 11'd2047;
			end
			program_regs(thr, tgt, gp, gi, gd, lim, sec, len);
			far_bias = p[0];
			calm = (p == 8);
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end)
				run_scan();
		end

		settle();
		$display("exercised %0d items and %0d commands across %0d register settings",
			items_sent, cmds_seen, settings_used);
		if (mismatches == 0 && outstanding == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
